@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/sfd_pkg.sv @@
// ---------------------------------------------------------------------------
// Status frame decoder package
// Frame layout constants, arithmetic constants and the decoded frame word.
// ---------------------------------------------------------------------------
package sfd_pkg;

    localparam logic [7:0]  SYNC_BYTE      = 8'h41;
    localparam int          POS_BATTERY    = 1;
    localparam int          POS_PERIOD_HI  = 3;
    localparam int          POS_PERIOD_LO  = 4;
    localparam int          POS_CHECK      = 6;
    localparam int          POS_FLAGS      = 7;
    localparam int          POS_POWER      = 8;
    localparam int          POS_TEMP       = 9;
    localparam int          BRAKE_BIT      = 5;

    localparam logic [15:0] SPEED_DIVIDEND = 16'd60000;
    localparam logic [16:0] SPEED_MAX      = 17'd131071;
    localparam logic [15:0] SCALE_RESET    = 16'd10192;
    localparam int          SCALE_FRAC     = 13;
    localparam logic [32:0] ROUND_HALF     = 33'd4096;
    localparam logic [11:0] POWER_FACTOR   = 12'd13;
    localparam logic signed [8:0] TEMP_OFFSET = 9'sd15;
    localparam logic [7:0]  BATTERY_MAX    = 8'd16;

    typedef struct packed {
        logic [15:0]       period;
        logic [4:0]        battery_level;
        logic [11:0]       power_watts;
        logic signed [8:0] motor_temp;
        logic              braking;
    } frame_t;

endpackage

@@ hdl/ebike_status_frame_decoder.sv @@
// ---------------------------------------------------------------------------
// E-bike status frame decoder
// Finds status frames in a received byte stream and decodes their values.
// ---------------------------------------------------------------------------
// Bytes enter on rx_byte with push; a byte is taken when push is high and
// full is low. Each byte shifts into a FRAME_LEN byte window; a frame is
// found once the window has refilled since the last frame, starts with the
// sync byte and carries a matching XOR check byte.
// Decoded frames wait in a FRAME_QUEUE_DEPTH entry queue. The back end takes
// one at a time and computes the speed with a restoring divider, one quotient
// bit per cycle, followed by a multiply step and a rounding step.
// A frame with a zero period skips the divider and goes to the multiply step.
// The back end takes no new frame from the queue until the last one has left
// the rounding step for the output register.
// Results leave through empty and pop; one result is held in an output
// register, and while the receiver stalls the back end and then the frame
// queue fill, after which full rises and bytes are held off.
// Reset clears the window, the fill count, the queue and the output valid
// flag and loads the speed scale with its default; cfg_we writes a new scale.

module ebike_status_frame_decoder #(
    parameter int FRAME_LEN         = 12,
    parameter int FRAME_QUEUE_DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        rx_byte,
    output logic              empty,
    input  logic              pop,
    output logic [16:0]       speed_tenths,
    output logic [4:0]        battery_level,
    output logic [11:0]       power_watts,
    output logic signed [8:0] motor_temp,
    output logic              braking,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata
);

    logic [15:0]     scale_reg;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    sfd_pkg::frame_t q_wframe;
    sfd_pkg::frame_t q_rframe;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= sfd_pkg::SCALE_RESET;
        end
        else if (cfg_we)
        begin
            scale_reg <= cfg_wdata;
        end
    end

    sfd_front #(
        .FRAME_LEN (FRAME_LEN)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .rx_byte (rx_byte),
        .q_push  (q_push),
        .q_frame (q_wframe),
        .q_full  (q_full)
    );

    sfd_fifo #(
        .WIDTH ($bits(sfd_pkg::frame_t)),
        .DEPTH (FRAME_QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .full  (q_full),
        .wdata (q_wframe),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_rframe)
    );

    sfd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .q_frame         (q_rframe),
        .speed_scale_q13 (scale_reg),
        .empty           (empty),
        .pop             (pop),
        .speed_tenths    (speed_tenths),
        .battery_level   (battery_level),
        .power_watts     (power_watts),
        .motor_temp      (motor_temp),
        .braking         (braking)
    );

endmodule

@@ hdl/sfd_front.sv @@
// ---------------------------------------------------------------------------
// Status frame decoder front end
// Shifts received bytes into the frame window, detects frames and queues them.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sfd_front #(
    parameter int FRAME_LEN = 12
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  logic [7:0]     rx_byte,
    output logic           q_push,
    output sfd_pkg::frame_t q_frame,
    input  logic           q_full
);

    localparam int FILL_W = $clog2(FRAME_LEN + 1);

    logic [7:0]        window_reg [FRAME_LEN];
    logic [7:0]        window_next [FRAME_LEN];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] fill_inc;
    logic [7:0]        check;
    logic              hit;
    logic              accept;

    assign full   = q_full;
    assign accept = push && !full;

    always_comb
    begin
        for (int i = 0; i < FRAME_LEN - 1; i++)
        begin
            window_next[i] = window_reg[i + 1];
        end
        window_next[FRAME_LEN - 1] = rx_byte;
        check = 8'd0;
        for (int i = 1; i < FRAME_LEN; i++)
        begin
            if (i != sfd_pkg::POS_CHECK)
            begin
                check = check ^ window_next[i];
            end
        end
    end

    assign fill_inc = (fill_reg < FILL_W'(FRAME_LEN)) ? fill_reg + 1'b1 : fill_reg;
    assign hit      = (fill_inc == FILL_W'(FRAME_LEN))
                   && (window_next[0] == sfd_pkg::SYNC_BYTE)
                   && (window_next[sfd_pkg::POS_CHECK] == check);
    assign fill_next = hit ? '0 : fill_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            for (int i = 0; i < FRAME_LEN; i++)
            begin
                window_reg[i] <= 8'd0;
            end
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
            for (int i = 0; i < FRAME_LEN; i++)
            begin
                window_reg[i] <= window_next[i];
            end
        end
    end

    assign q_push = accept && hit;

    always_comb
    begin
        q_frame.period = {window_next[sfd_pkg::POS_PERIOD_HI],
                          window_next[sfd_pkg::POS_PERIOD_LO]};
        q_frame.battery_level = (window_next[sfd_pkg::POS_BATTERY] > sfd_pkg::BATTERY_MAX)
                              ? sfd_pkg::BATTERY_MAX[4:0]
                              : window_next[sfd_pkg::POS_BATTERY][4:0];
        q_frame.power_watts = {4'd0, window_next[sfd_pkg::POS_POWER]}
                            * sfd_pkg::POWER_FACTOR;
        q_frame.motor_temp = signed'({window_next[sfd_pkg::POS_TEMP][7],
                                      window_next[sfd_pkg::POS_TEMP]})
                           + sfd_pkg::TEMP_OFFSET;
        q_frame.braking = window_next[sfd_pkg::POS_FLAGS][sfd_pkg::BRAKE_BIT];
    end

    `ASSERT_IMPL(a_fill_range, 1'b1, fill_reg <= FILL_W'(FRAME_LEN))
    `ASSERT_NEXT(a_frame_restarts_fill, q_push, fill_reg == '0)
    `ASSERT_IMPL(a_no_push_when_full, q_push, !q_full)

endmodule

@@ hdl/sfd_fifo.sv @@
// ---------------------------------------------------------------------------
// Status frame decoder frame queue
// Small first-in first-out queue between the front end and the back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sfd_fifo #(
    parameter int WIDTH = 43,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `ASSERT_IMPL(a_count_range, 1'b1, count_reg <= CNT_W'(DEPTH))
    `ASSERT_NEXT(a_push_grows, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1)
    `ASSERT_NEXT(a_pop_shrinks, do_pop && !do_push, count_reg == $past(count_reg) - 1'b1)

endmodule

@@ hdl/sfd_back.sv @@
// ---------------------------------------------------------------------------
// Status frame decoder back end
// Divides the speed dividend by the period, scales, rounds and holds the result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sfd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    output logic              q_pop,
    input  sfd_pkg::frame_t   q_frame,
    input  logic [15:0]       speed_scale_q13,
    output logic              empty,
    input  logic              pop,
    output logic [16:0]       speed_tenths,
    output logic [4:0]        battery_level,
    output logic [11:0]       power_watts,
    output logic signed [8:0] motor_temp,
    output logic              braking
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_ROUND
    } state_t;

    state_t          state_reg;
    logic [3:0]      cnt_reg;
    logic [15:0]     quo_reg;
    logic [15:0]     rem_reg;
    logic [15:0]     div_reg;
    logic [31:0]     prod_reg;
    sfd_pkg::frame_t frame_reg;
    logic            out_valid_reg;

    logic [16:0]     trial;
    logic            ge;
    logic [16:0]     diff;
    logic [15:0]     rem_next;
    logic [32:0]     rsum;
    logic [19:0]     scaled;
    logic [16:0]     speed_next;
    logic            out_free;

    assign trial    = {rem_reg, quo_reg[15]};
    assign ge       = (trial >= {1'b0, div_reg});
    assign diff     = trial - {1'b0, div_reg};
    assign rem_next = ge ? diff[15:0] : trial[15:0];

    assign rsum       = {1'b0, prod_reg} + sfd_pkg::ROUND_HALF;
    assign scaled     = rsum[32:sfd_pkg::SCALE_FRAC];
    assign speed_next = (scaled > {3'd0, sfd_pkg::SPEED_MAX}) ? sfd_pkg::SPEED_MAX
                                                             : scaled[16:0];

    assign out_free = !out_valid_reg || pop;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign empty    = !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if ((state_reg == ST_ROUND) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        frame_reg <= q_frame;
                        div_reg   <= q_frame.period;
                        rem_reg   <= 16'd0;
                        cnt_reg   <= '0;
                        if (q_frame.period == 16'd0)
                        begin
                            quo_reg   <= 16'd0;
                            state_reg <= ST_MUL;
                        end
                        else
                        begin
                            quo_reg   <= sfd_pkg::SPEED_DIVIDEND;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= {quo_reg[14:0], ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 4'd15)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= quo_reg * speed_scale_q13;
                    state_reg <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    if (out_free)
                    begin
                        speed_tenths  <= speed_next;
                        battery_level <= frame_reg.battery_level;
                        power_watts   <= frame_reg.power_watts;
                        motor_temp    <= frame_reg.motor_temp;
                        braking       <= frame_reg.braking;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `ASSERT_NEXT(a_result_held, out_valid_reg && !pop, out_valid_reg && $stable(speed_tenths))
    `ASSERT_IMPL(a_take_only_idle, q_pop, state_reg == ST_IDLE)
    `ASSERT_NEXT(a_div_runs, (state_reg == ST_DIV) && (cnt_reg != 4'd15), state_reg == ST_DIV)

endmodule
